// ===== design/txd_pkg.sv =====
// ----------------------------------------------------------------------------
// txd_pkg
// Shared types and codes of the tiled texel decoder: beat layouts,
// position record and register indexes.
// ----------------------------------------------------------------------------
package txd_pkg;

  // item kinds
  localparam logic KIND_TEXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
  localparam int unsigned CFG_DATA_W = 8;

  // texel formats
  localparam logic FMT_DIRECT  = 1'b0;
  localparam logic FMT_PALETTE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] texel_word;
    logic [7:0]  palette_slot;
    logic [15:0] palette_word;
    logic [7:0]  back_red;
    logic [7:0]  back_green;
    logic [7:0]  back_blue;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [6:0] x;
    logic [5:0] y;
    logic       last;
  } pos_t;

endpackage

// ===== design/txd_ram.sv =====
// ----------------------------------------------------------------------------
// txd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module txd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/txd_pos.sv =====
// ----------------------------------------------------------------------------
// txd_pos
// Configuration registers and tiled position counters. Gives the pixel
// position of the texel presented now and steps on each accepted texel.
// ----------------------------------------------------------------------------
module txd_pos import txd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output logic                  fmt,
  output pos_t                  pos
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XSW = (XW + 1 > 7) ? XW + 1 : 7;
  localparam int unsigned YSW = (YW + 1 > 6) ? YW + 1 : 6;

  logic          fmt_r, fmt_nxt;
  logic [7:0]    width_r, width_nxt;
  logic [6:0]    height_r, height_nxt;
  logic [XW-1:0] tcol_r, tcol_nxt;
  logic [YW-1:0] trow_r, trow_nxt;
  logic [2:0]    icol_r, icol_nxt;
  logic [1:0]    irow_r, irow_nxt;

  logic [3:0]     tw;
  logic [2:0]     tw_last;
  logic [XW-1:0]  w_clamp, w_eff;
  logic [YW-1:0]  h_clamp, h_eff;
  logic           icol_end, col_end, row_end, last;
  logic [XSW-1:0] x_sum;
  logic [YSW-1:0] y_sum;

  // tile width follows the format
  assign tw      = (fmt_r == FMT_PALETTE) ? 4'd8 : 4'd4;
  assign tw_last = (fmt_r == FMT_PALETTE) ? 3'd7 : 3'd3;

  // clamp image size and round down to whole tiles
  always_comb begin
    if (width_r < 8'd8) begin
      w_clamp = XW'(8);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_clamp = XW'(MAX_WIDTH);
    end else begin
      w_clamp = XW'(width_r);
    end
    if (height_r < 7'd4) begin
      h_clamp = YW'(4);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_clamp = YW'(MAX_HEIGHT);
    end else begin
      h_clamp = YW'(height_r);
    end
  end

  assign w_eff = {w_clamp[XW-1:3], (fmt_r == FMT_PALETTE) ? 1'b0 : w_clamp[2], 2'b00};
  assign h_eff = {h_clamp[YW-1:2], 2'b00};

  // end of tile row, image row and image
  assign icol_end = icol_r >= tw_last;
  assign col_end  = ({1'b0, tcol_r} + (XW + 1)'(tw)) >= {1'b0, w_eff};
  assign row_end  = ({1'b0, trow_r} + (YW + 1)'(4)) >= {1'b0, h_eff};
  assign last     = icol_end && (irow_r == 2'd3) && col_end && row_end;

  // current pixel position
  assign x_sum = XSW'(tcol_r) + XSW'(icol_r);
  assign y_sum = YSW'(trow_r) + YSW'(irow_r);

  assign fmt      = fmt_r;
  assign pos.x    = x_sum[6:0];
  assign pos.y    = y_sum[5:0];
  assign pos.last = last;

  // register writes and counter stepping
  always_comb begin
    fmt_nxt    = fmt_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    tcol_nxt   = tcol_r;
    trow_nxt   = trow_r;
    icol_nxt   = icol_r;
    irow_nxt   = irow_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: fmt_nxt    = cfg_data[0];
        CFG_WIDTH:  width_nxt  = cfg_data;
        CFG_HEIGHT: height_nxt = cfg_data[6:0];
        default:    ;
      endcase
      tcol_nxt = '0;
      trow_nxt = '0;
      icol_nxt = '0;
      irow_nxt = '0;
    end else if (step) begin
      if (last) begin
        tcol_nxt = '0;
        trow_nxt = '0;
        icol_nxt = '0;
        irow_nxt = '0;
      end else if (icol_end) begin
        icol_nxt = '0;
        irow_nxt = irow_r + 2'd1;
        if (irow_r == 2'd3) begin
          tcol_nxt = tcol_r + XW'(tw);
          if (col_end) begin
            tcol_nxt = '0;
            trow_nxt = trow_r + YW'(4);
            if (row_end) begin
              trow_nxt = '0;
            end
          end
        end
      end else begin
        icol_nxt = icol_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_DIRECT;
      width_r  <= 8'd96;
      height_r <= 7'd32;
      tcol_r   <= '0;
      trow_r   <= '0;
      icol_r   <= '0;
      irow_r   <= '0;
    end else begin
      fmt_r    <= fmt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      tcol_r   <= tcol_nxt;
      trow_r   <= trow_nxt;
      icol_r   <= icol_nxt;
      irow_r   <= irow_nxt;
    end
  end

endmodule

// ===== design/txd_blend.sv =====
// ----------------------------------------------------------------------------
// txd_blend
// RGB5A3 colour decode. Registers the weighted sums of the alpha blend,
// then divides by 255 and picks the opaque or blended colour.
// ----------------------------------------------------------------------------
module txd_blend import txd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] word,
  input  rgb_t        bg,
  output rgb_t        color
);

  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand3(input logic [2:0] v);
    expand3 = {v, v, v[2:1]};
  endfunction

  function automatic logic [7:0] expand4(input logic [3:0] v);
    expand4 = {v, v};
  endfunction

  // weighted sum c*a + bg*(255-a), bounded by 255*255
  function automatic logic [15:0] wsum(input logic [7:0] c, input logic [7:0] a,
                                       input logic [7:0] b);
    logic [7:0] ia;
    ia   = 8'd255 - a;
    wsum = ({8'd0, c} * {8'd0, a}) + ({8'd0, b} * {8'd0, ia});
  endfunction

  // exact floor(x/255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t      = x + 16'd1 + {8'd0, x[15:8]};
    div255 = t[15:8];
  endfunction

  logic        opaque;
  logic [7:0]  alpha;
  logic        opaque_r;
  rgb_t        solid_r;
  logic [15:0] sum_r_r, sum_g_r, sum_b_r;

  assign opaque = word[15];
  assign alpha  = expand3(word[14:12]);

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      opaque_r      <= opaque;
      solid_r.red   <= expand5(word[14:10]);
      solid_r.green <= expand5(word[9:5]);
      solid_r.blue  <= expand5(word[4:0]);
      sum_r_r       <= wsum(expand4(word[11:8]), alpha, bg.red);
      sum_g_r       <= wsum(expand4(word[7:4]), alpha, bg.green);
      sum_b_r       <= wsum(expand4(word[3:0]), alpha, bg.blue);
    end
  end

  // divide and select
  always_comb begin
    if (opaque_r) begin
      color = solid_r;
    end else begin
      color.red   = div255(sum_r_r);
      color.green = div255(sum_g_r);
      color.blue  = div255(sum_b_r);
    end
  end

endmodule

// ===== design/tiled_rgb5a3_ci8_texel_decoder.sv =====
// An accepted texel beat passes the input, product and output registers to out_valid.
// Throughput: one beat per cycle while not stalled; palette writes take a slot and give no result.
// The stages are the palette RAM registered read, the blend product register
// and the output register; a stalled output holds all three stages.
// Reset clears the pipeline valids and counters and loads the register defaults;
// palette contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// tiled_rgb5a3_ci8_texel_decoder
// Decodes tiled RGB5A3 or palette-indexed texels to 8-bit RGB with pixel
// position and an end-of-image flag.
// ----------------------------------------------------------------------------
module tiled_rgb5a3_ci8_texel_decoder import txd_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = 128,
  parameter int unsigned MAX_HEIGHT    = 64,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_beat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PW = $clog2(PALETTE_DEPTH);

  logic        en, acc, tex_acc, pal_we, cfg_we;
  logic        fmt;
  pos_t        cur_pos;
  logic [15:0] ram_rdata;
  logic [15:0] word_sel;
  rgb_t        color;

  logic        s1_valid_r;
  logic        s1_fmt_r;
  logic [15:0] s1_word_r;
  rgb_t        s1_bg_r;
  pos_t        s1_pos_r;
  logic        s2_valid_r;
  pos_t        s2_pos_r;
  logic        out_valid_r;
  out_beat_t   out_beat_r;

  // handshakes
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign tex_acc  = acc && (in_beat.kind == KIND_TEXEL);
  assign pal_we   = acc && (in_beat.kind == KIND_PALETTE);
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // config and position
  txd_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (tex_acc),
    .fmt      (fmt),
    .pos      (cur_pos)
  );

  // palette store
  txd_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_we),
    .wr_addr(in_beat.palette_slot[PW-1:0]),
    .wr_data(in_beat.palette_word),
    .rd_en  (en),
    .rd_addr(in_beat.texel_word[PW-1:0]),
    .rd_data(ram_rdata)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= tex_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fmt_r      <= fmt;
      s1_word_r     <= in_beat.texel_word;
      s1_bg_r.red   <= in_beat.back_red;
      s1_bg_r.green <= in_beat.back_green;
      s1_bg_r.blue  <= in_beat.back_blue;
      s1_pos_r      <= cur_pos;
    end
  end

  assign word_sel = (s1_fmt_r == FMT_PALETTE) ? ram_rdata : s1_word_r;

  // colour decode and blend
  txd_blend u_blend (
    .clk  (clk),
    .en   (en),
    .word (word_sel),
    .bg   (s1_bg_r),
    .color(color)
  );

  // product stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos_r <= s1_pos_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r.pixel_x    <= s2_pos_r.x;
      out_beat_r.pixel_y    <= s2_pos_r.y;
      out_beat_r.red        <= color.red;
      out_beat_r.green      <= color.green;
      out_beat_r.blue       <= color.blue;
      out_beat_r.last_pixel <= s2_pos_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  // palette writes never enter the texel pipeline
  assert property (@(posedge clk) disable iff (!rst_n) pal_we |=> !s1_valid_r)
    else $error("palette write produced a texel in the input stage");

  // texels move forward whenever the pipeline advances
  assert property (@(posedge clk) disable iff (!rst_n) (en && s1_valid_r) |=> s2_valid_r)
    else $error("texel lost between input and product stage");

  assert property (@(posedge clk) disable iff (!rst_n) (en && s2_valid_r) |=> out_valid_r)
    else $error("texel lost between product and output stage");

  // a held pipeline keeps its middle stage
  assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(s2_valid_r))
    else $error("product stage changed while the output was held");

  // a register write restarts the image at the origin
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (cur_pos.x == 7'd0) && (cur_pos.y == 6'd0))
    else $error("position not cleared by a register write");
`endif

endmodule

// ===== dv/tb_tiled_rgb5a3_ci8_texel_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiled_rgb5a3_ci8_texel_decoder
// Self-checking bench for the tiled texel decoder. A queue-fed driver streams
// texel and palette-load beats while a monitor compares every output pixel
// against a behavioral decoder that tracks palette, registers and tile
// position. Runs go through several image geometries, both texel formats
// and several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_tiled_rgb5a3_ci8_texel_decoder;
  import txd_pkg::*;

  // index past the register list, still clears the position counters
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned WATCHDOG_NS = 200000 * 12;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // stimulus and expected pixel stores
  in_beat_t    feed_beats[$];
  out_beat_t   pending_pixels[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  // palette slots loaded so far in stream order
  bit          slot_loaded[256];
  int unsigned loaded_slots[$];

  // decoder copy: registers, palette and tile position
  logic        cur_fmt = FMT_DIRECT;
  logic [7:0]  cur_width = 8'd96;
  logic [6:0]  cur_height = 7'd32;
  logic [15:0] palette_copy[256];
  int unsigned tile_x = 0;
  int unsigned tile_y = 0;
  int unsigned sub_x = 0;
  int unsigned sub_y = 0;

  tiled_rgb5a3_ci8_texel_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #6 clk = ~clk;

  task automatic note_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got !== want) begin
      note_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // channel blend of a translucent texel over the background
  function automatic logic [7:0] mix_over(int unsigned c, int unsigned a, int unsigned bgv);
    return 8'((c * a + bgv * (255 - a)) / 255);
  endfunction

  function automatic rgb_t decode_rgb5a3(logic [15:0] wd, logic [7:0] br, logic [7:0] bgr,
                                         logic [7:0] bb);
    rgb_t        px;
    logic [7:0]  alpha;
    if (wd[15]) begin
      px.red   = {wd[14:10], wd[14:12]};
      px.green = {wd[9:5], wd[9:7]};
      px.blue  = {wd[4:0], wd[4:2]};
    end else begin
      alpha    = {wd[14:12], wd[14:12], wd[14:13]};
      px.red   = mix_over({wd[11:8], wd[11:8]}, alpha, br);
      px.green = mix_over({wd[7:4], wd[7:4]}, alpha, bgr);
      px.blue  = mix_over({wd[3:0], wd[3:0]}, alpha, bb);
    end
    return px;
  endfunction

  task automatic clear_position();
    tile_x = 0;
    tile_y = 0;
    sub_x  = 0;
    sub_y  = 0;
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FORMAT: cur_fmt = data[0];
      CFG_WIDTH:  cur_width = data;
      CFG_HEIGHT: cur_height = data[6:0];
      default: ;
    endcase
    clear_position();
  endtask

  // one accepted input beat: palette load or texel to expected pixel
  task automatic absorb_beat(in_beat_t b);
    int unsigned tw;
    int unsigned w;
    int unsigned h;
    logic [15:0] word;
    rgb_t        px;
    out_beat_t   r;
    bit          last;
    if (b.kind == KIND_PALETTE) begin
      palette_copy[b.palette_slot] = b.palette_word;
      return;
    end
    tw = (cur_fmt == FMT_PALETTE) ? 8 : 4;
    w = cur_width;
    if (w < 8) w = 8;
    if (w > 128) w = 128;
    w &= ~(tw - 1);
    h = cur_height;
    if (h < 4) h = 4;
    if (h > 64) h = 64;
    h &= ~32'd3;
    word = (cur_fmt == FMT_PALETTE) ? palette_copy[b.texel_word[7:0]] : b.texel_word;
    px = decode_rgb5a3(word, b.back_red, b.back_green, b.back_blue);
    last = (sub_x + 1 >= tw) && (sub_y == 3) && (tile_x + tw >= w) && (tile_y + 4 >= h);
    r.pixel_x    = 7'(tile_x + sub_x);
    r.pixel_y    = 6'(tile_y + sub_y);
    r.red        = px.red;
    r.green      = px.green;
    r.blue       = px.blue;
    r.last_pixel = last;
    pending_pixels.push_back(r);
    // column within tile, row within tile, then tile across and down
    sub_x++;
    if (sub_x >= tw) begin
      sub_x = 0;
      sub_y++;
      if (sub_y >= 4) begin
        sub_y = 0;
        tile_x += tw;
        if (tile_x >= w) begin
          tile_x = 0;
          tile_y += 4;
          if (tile_y >= h) tile_y = 0;
        end
      end
    end
    if (last) clear_position();
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_beat(in_beat);
      if (!in_valid || !in_stall) begin
        if (feed_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= feed_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin : pixel_monitor
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          note_error($sformatf("unexpected pixel x=%0d y=%0d", out_beat.pixel_x,
                               out_beat.pixel_y));
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", out_beat.pixel_x, want.pixel_x);
          check_field("pixel_y", out_beat.pixel_y, want.pixel_y);
          check_field("red", out_beat.red, want.red);
          check_field("green", out_beat.green, want.green);
          check_field("blue", out_beat.blue, want.blue);
          check_field("last_pixel", out_beat.last_pixel, want.last_pixel);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // register write over the config channel
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // all beats taken, all pixels seen, pipeline drained
  task automatic wait_idle();
    int unsigned quiet;
    quiet = 0;
    while (quiet < DRAIN_CYCLES) begin
      @(posedge clk);
      if (feed_beats.size() != 0 || in_valid || pending_pixels.size() != 0) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
  endtask

  function automatic in_beat_t mk_beat(logic kind, logic [15:0] tw, logic [7:0] slot,
                                       logic [15:0] pw, logic [7:0] br, logic [7:0] bgr,
                                       logic [7:0] bb);
    in_beat_t b;
    b.kind         = kind;
    b.texel_word   = tw;
    b.palette_slot = slot;
    b.palette_word = pw;
    b.back_red     = br;
    b.back_green   = bgr;
    b.back_blue    = bb;
    return b;
  endfunction

  task automatic push_palette_load(logic [7:0] slot, logic [15:0] pw, in_beat_t b);
    b.kind         = KIND_PALETTE;
    b.palette_slot = slot;
    b.palette_word = pw;
    feed_beats.push_back(b);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endtask

  function automatic in_beat_t random_beat();
    return mk_beat(1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // one random phase: registers, idle mix, then a stream of beats
  task automatic run_phase(int unsigned send_pct, int unsigned stall_pct, logic fmt,
                           logic [7:0] width, logic [6:0] height, int unsigned n_beats,
                           int unsigned load_pct);
    in_beat_t b;
    wait_idle();
    cfg_write(CFG_SPARE, 8'($urandom));
    cfg_write(CFG_FORMAT, {7'($urandom), fmt});
    cfg_write(CFG_WIDTH, width);
    cfg_write(CFG_HEIGHT, {1'($urandom), height});
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n_beats; i++) begin
      b = random_beat();
      if ($urandom_range(99) < load_pct) begin
        push_palette_load(b.palette_slot, b.palette_word, b);
      end else begin
        b.kind = KIND_TEXEL;
        if (fmt == FMT_PALETTE)
          b.texel_word[7:0] = 8'(loaded_slots[$urandom_range(loaded_slots.size() - 1)]);
        feed_beats.push_back(b);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: direct texels, alpha and opaque corners
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h0000, 8'h00, 16'h0000, 8'hff, 8'hff, 8'hff));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'hffff, 8'hff, 16'hffff, 8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h8000, 8'h00, 16'h0000, 8'hff, 8'hff, 8'hff));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h7fff, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h7000, 8'h00, 16'h0000, 8'hff, 8'hff, 8'hff));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h0fff, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h3a5c, 8'h00, 16'h0000, 8'h80, 8'h40, 8'hc0));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'hd5aa, 8'h00, 16'h0000, 8'h12, 8'h34, 8'h56));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h4123, 8'h00, 16'h0000, 8'hff, 8'h00, 8'h7f));
    // palette loads at the slot extremes and three inner slots
    push_palette_load(8'h00, 16'hffff, '0);
    push_palette_load(8'hff, 16'h0000, '0);
    push_palette_load(8'h80, 16'h7fff, '0);
    push_palette_load(8'h55, 16'h3c96, '0);
    push_palette_load(8'haa, 16'h8000, '0);
    wait_idle();

    // smallest palette image, index reads with junk in the upper texel bits
    cfg_write(CFG_FORMAT, {7'd0, FMT_PALETTE});
    cfg_write(CFG_WIDTH, 8'd8);
    cfg_write(CFG_HEIGHT, 8'd4);
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'hff00, 8'hff, 16'hffff, 8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h00ff, 8'h00, 16'h0000, 8'hff, 8'hff, 8'hff));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h5a80, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'ha555, 8'h00, 16'h0000, 8'h9c, 8'h63, 8'hff));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h00aa, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00));
    // reload a slot and read it straight back
    push_palette_load(8'h00, 16'h1234, mk_beat(KIND_PALETTE, 16'h0000, 8'h00, 16'h0000,
                                                8'h00, 8'h00, 8'h00));
    feed_beats.push_back(mk_beat(KIND_TEXEL, 16'h0000, 8'h00, 16'h0000, 8'hf0, 8'h0f, 8'h88));

    // random phases across geometries and idle mixes
    run_phase(0, 0, FMT_PALETTE, 8'd8, 7'd4, 80, 20);
    run_phase(73, 0, FMT_DIRECT, 8'd0, 7'd5, 70, 15);
    run_phase(0, 73, FMT_PALETTE, 8'd255, 7'd0, 90, 8);
    run_phase(26, 26, FMT_DIRECT, 8'd8, 7'd127, 90, 8);
    run_phase(73, 0, FMT_PALETTE, 8'd20, 7'd9, 50, 15);
    run_phase(0, 73, FMT_DIRECT, 8'd13, 7'd64, 50, 15);
    run_phase(26, 26, FMT_PALETTE, 8'd128, 7'd63, 50, 15);
    wait_idle();

    if (error_count == 0) begin
      $display("tiled_rgb5a3_ci8_texel_decoder regression: pass");
    end else begin
      $display("tiled_rgb5a3_ci8_texel_decoder regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("tiled_rgb5a3_ci8_texel_decoder regression: fail");
    $finish;
  end

endmodule
